>>> design/rotary_encoder_filter_decoder_assert.svh
// Assertion macros used by the rotary encoder decoder top level.
`ifndef ROTARY_ENCODER_FILTER_DECODER_ASSERT_SVH
`define ROTARY_ENCODER_FILTER_DECODER_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define ROTENC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ROTENC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> design/rotenc_pkg.sv
// Shared types and constants of the rotary encoder decoder.
`timescale 1ns / 1ps

package rotenc_pkg;

  localparam int CHANNELS = 8;
  localparam int PIN_W = 8;
  localparam int CHAN_W = 3;
  localparam int CNT_W = 8;

  localparam int IN_TDATA_W = 24;
  localparam int IN_PAD_W = IN_TDATA_W - 2 * PIN_W - CHAN_W;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W = OUT_TDATA_W - 1 - 2 * PIN_W;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0] CEILING_RESET = 8'd10;
  localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd3;

  typedef enum logic [1:0] {
    KIND_SAMPLE   = 2'd0,
    KIND_DETECT   = 2'd1,
    KIND_READ_CW  = 2'd2,
    KIND_READ_CCW = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_CEILING   = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_SWAP      = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] ceiling;
    logic [CNT_W-1:0] threshold;
    logic             swap;
  } cfg_t;

  typedef struct packed {
    logic sample;
    logic detect;
    logic clr_cw;
    logic clr_ccw;
    logic clk_pin;
    logic dt_pin;
  } chan_cmd_t;

endpackage

>>> design/rotary_encoder_filter_decoder.sv
// Top level of the eight-channel rotary encoder filter and step decoder.
`timescale 1ns / 1ps
`include "rotary_encoder_filter_decoder_assert.svh"

// Usage:
//   Input stream (s_*): one transfer per command. s_tuser carries the kind:
//   sample pins, detect edges, read-and-clear clockwise or counter-clockwise
//   flag. s_tdata carries clock pins, data pins and the channel to read.
//   Output stream (m_*): exactly one transfer per input command, in order,
//   with step_seen and the clockwise / counter-clockwise pending maps as
//   they stand after the command.
//   Path: a taken command sits in the input register; when it advances, the
//   channels update and its result is loaded and offered on m_* from then on.
//   Throughput: one command per cycle unless m_* stalls, set by the single
//   update stage that runs every channel's counters and flags in parallel.
//   Stall: the result register holds while m_tready is low; one more
//   command can sit in the input register, after which s_tready drops.
//   Reset (rst, synchronous): counters, edge history, flags and both stream
//   stages clear; registers return to ceiling 10, threshold 3, no swap.
//   Config (APB) must be written only while no command is in flight; the block does not enforce it.
module rotary_encoder_filter_decoder
  import rotenc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // s_tdata: clk_pins[7:0], dt_pins[15:8], channel[18:16], zero pad above
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // s_tuser: kind[1:0]
  input  logic [1:0]             s_tuser,
  // m_tdata: step_seen[0], cw_pending[8:1], ccw_pending[16:9], zero pad above
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  cfg_t cfg;

  // input register
  logic              in_valid;
  kind_t             in_kind;
  logic [PIN_W-1:0]  in_clk_pins;
  logic [PIN_W-1:0]  in_dt_pins;
  logic [CHAN_W-1:0] in_channel;

  // result register
  logic              out_valid;
  logic              res_step_seen;
  logic [PIN_W-1:0]  res_cw;
  logic [PIN_W-1:0]  res_ccw;

  logic                advance;
  logic [CHANNELS-1:0] cw_flag, ccw_flag, cw_next, ccw_next, seen_vec;
  logic [PIN_W-1:0]    pend_cw, pend_ccw;
  logic                is_sample, is_detect, is_rd_cw, is_rd_ccw;

  rotenc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // an item moves on when the result slot is free or being drained
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind     <= kind_t'(s_tuser);
      in_clk_pins <= s_tdata[PIN_W-1:0];
      in_dt_pins  <= s_tdata[2*PIN_W-1:PIN_W];
      in_channel  <= s_tdata[2*PIN_W+CHAN_W-1:2*PIN_W];
    end
  end

  assign is_sample = advance && (in_kind == KIND_SAMPLE);
  assign is_detect = advance && (in_kind == KIND_DETECT);
  assign is_rd_cw  = advance && (in_kind == KIND_READ_CW);
  assign is_rd_ccw = advance && (in_kind == KIND_READ_CCW);

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    logic      sel;
    chan_cmd_t cmd;

    assign sel = ({{(32-CHAN_W){1'b0}}, in_channel} == 32'(i));

    assign cmd.sample  = is_sample;
    assign cmd.detect  = is_detect;
    assign cmd.clr_cw  = is_rd_cw && sel;
    assign cmd.clr_ccw = is_rd_ccw && sel;

    // channels past the pin bus always sample low
    if (i < PIN_W) begin : g_pin
      assign cmd.clk_pin = in_clk_pins[i];
      assign cmd.dt_pin  = in_dt_pins[i];
    end else begin : g_nopin
      assign cmd.clk_pin = 1'b0;
      assign cmd.dt_pin  = 1'b0;
    end

    assign seen_vec[i] = (cmd.clr_cw && cw_flag[i]) || (cmd.clr_ccw && ccw_flag[i]);

    rotenc_channel u_chan (
      .clk      (clk),
      .rst      (rst),
      .cfg      (cfg),
      .cmd      (cmd),
      .cw_flag  (cw_flag[i]),
      .ccw_flag (ccw_flag[i]),
      .cw_next  (cw_next[i]),
      .ccw_next (ccw_next[i])
    );
  end

  // pending maps show only the channels that have a pin on the bus
  for (genvar p = 0; p < PIN_W; p++) begin : g_pend
    if (p < CHANNELS) begin : g_on
      assign pend_cw[p]  = cw_next[p];
      assign pend_ccw[p] = ccw_next[p];
    end else begin : g_off
      assign pend_cw[p]  = 1'b0;
      assign pend_ccw[p] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_step_seen <= |seen_vec;
      res_cw        <= pend_cw;
      res_ccw       <= pend_ccw;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, res_ccw, res_cw, res_step_seen};

  `ROTENC_ASSERT_NEXT(a_in_hold, in_valid && !advance, in_valid && $stable(in_channel) && $stable(in_kind), "blocked input register changed")
  `ROTENC_ASSERT_NEXT(a_result_loaded, advance, out_valid, "processed item produced no result")
  `ROTENC_ASSERT_NEXT(a_seen_only_read, advance && (in_kind == KIND_SAMPLE || in_kind == KIND_DETECT), !res_step_seen, "step_seen set by non-read item")
  `ROTENC_ASSERT_NOW(a_seen_one_hot, 1'b1, $onehot0(seen_vec), "more than one channel cleared")

endmodule

>>> design/rotenc_regs.sv
// APB register file: filter ceiling, edge threshold, direction swap.
`timescale 1ns / 1ps

module rotenc_regs
  import rotenc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ceiling   <= CEILING_RESET;
      cfg.threshold <= THRESHOLD_RESET;
      cfg.swap      <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_CEILING:   cfg.ceiling   <= pwdata[CNT_W-1:0];
        REG_THRESHOLD: cfg.threshold <= pwdata[CNT_W-1:0];
        REG_SWAP:      cfg.swap      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CEILING:   prdata = {{(DATA_W-CNT_W){1'b0}}, cfg.ceiling};
      REG_THRESHOLD: prdata = {{(DATA_W-CNT_W){1'b0}}, cfg.threshold};
      REG_SWAP:      prdata = {{(DATA_W-1){1'b0}}, cfg.swap};
      default:       prdata = '0;
    endcase
  end

endmodule

>>> design/rotenc_channel.sv
// One encoder channel: pin filter counters, edge detect, direction flags.
`timescale 1ns / 1ps

module rotenc_channel
  import rotenc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  chan_cmd_t cmd,
  output logic      cw_flag,
  output logic      ccw_flag,
  output logic      cw_next,
  output logic      ccw_next
);

  logic [CNT_W-1:0] clk_cnt, clk_cnt_next;
  logic [CNT_W-1:0] dt_cnt, dt_cnt_next;
  logic             last_clk, last_clk_next;
  logic             clk_filt, dt_filt;

  // saturating up/down debounce counter
  function automatic logic [CNT_W-1:0] filter_move(
    input logic [CNT_W-1:0] count,
    input logic             high,
    input logic [CNT_W-1:0] ceiling
  );
    logic [CNT_W-1:0] res;
    res = count;
    if (high) begin
      if (count < ceiling) res = count + 8'd1;
    end else if (count != '0) begin
      res = count - 8'd1;
    end
    return res;
  endfunction

  assign clk_filt = clk_cnt > cfg.threshold;
  assign dt_filt  = dt_cnt > cfg.threshold;

  always_comb begin
    clk_cnt_next  = clk_cnt;
    dt_cnt_next   = dt_cnt;
    last_clk_next = last_clk;
    cw_next       = cw_flag;
    ccw_next      = ccw_flag;
    if (cmd.sample) begin
      clk_cnt_next = filter_move(clk_cnt, cmd.clk_pin, cfg.ceiling);
      dt_cnt_next  = filter_move(dt_cnt, cmd.dt_pin, cfg.ceiling);
    end
    if (cmd.detect) begin
      last_clk_next = clk_filt;
      if (!last_clk && clk_filt) begin
        if (dt_filt ^ cfg.swap) ccw_next = 1'b1;
        else                    cw_next  = 1'b1;
      end
    end
    if (cmd.clr_cw)  cw_next  = 1'b0;
    if (cmd.clr_ccw) ccw_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_cnt  <= '0;
      dt_cnt   <= '0;
      last_clk <= 1'b0;
      cw_flag  <= 1'b0;
      ccw_flag <= 1'b0;
    end else begin
      clk_cnt  <= clk_cnt_next;
      dt_cnt   <= dt_cnt_next;
      last_clk <= last_clk_next;
      cw_flag  <= cw_next;
      ccw_flag <= ccw_next;
    end
  end

endmodule

>>> sim/rotenc_checker.sv
// Scoreboard for the rotary encoder decoder: mirrors registers, predicts and checks results.
`timescale 1ns / 1ps

module rotenc_checker
  import rotenc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [1:0]             s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic                   pready,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output int                     mismatches,
  output int                     awaiting
);

  typedef struct packed {
    logic             step_seen;
    logic [PIN_W-1:0] cw_map;
    logic [PIN_W-1:0] ccw_map;
  } step_report_t;

  logic [CNT_W-1:0] ceiling;
  logic [CNT_W-1:0] threshold;
  logic             swap;

  logic [CNT_W-1:0] clk_count [CHANNELS];
  logic [CNT_W-1:0] dt_count [CHANNELS];
  logic             last_clk [CHANNELS];
  logic             cw_flag [CHANNELS];
  logic             ccw_flag [CHANNELS];

  step_report_t expected_reports[$];
  int miss_count = 0;

  assign mismatches = miss_count;

  // saturating debounce counter
  function automatic logic [CNT_W-1:0] debounce(input logic [CNT_W-1:0] count, input logic pin);
    if (pin) return (count < ceiling) ? count + 8'd1 : count;
    return (count != '0) ? count - 8'd1 : count;
  endfunction

  function automatic step_report_t decode_command(input kind_t kind,
                                                  input logic [PIN_W-1:0] clk_pins,
                                                  input logic [PIN_W-1:0] dt_pins,
                                                  input logic [CHAN_W-1:0] chan);
    step_report_t rep;
    logic now_hi;
    logic data_hi;
    rep = '0;
    case (kind)
      KIND_SAMPLE: begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          clk_count[ch] = debounce(clk_count[ch], clk_pins[ch]);
          dt_count[ch] = debounce(dt_count[ch], dt_pins[ch]);
        end
      end
      KIND_DETECT: begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          now_hi = clk_count[ch] > threshold;
          if (!last_clk[ch] && now_hi) begin
            data_hi = dt_count[ch] > threshold;
            if (data_hi ^ swap) ccw_flag[ch] = 1'b1;
            else cw_flag[ch] = 1'b1;
          end
          last_clk[ch] = now_hi;
        end
      end
      KIND_READ_CW: begin
        if (int'(chan) < CHANNELS && cw_flag[chan]) begin
          cw_flag[chan] = 1'b0;
          rep.step_seen = 1'b1;
        end
      end
      KIND_READ_CCW: begin
        if (int'(chan) < CHANNELS && ccw_flag[chan]) begin
          ccw_flag[chan] = 1'b0;
          rep.step_seen = 1'b1;
        end
      end
      default: ;
    endcase
    for (int ch = 0; ch < CHANNELS && ch < PIN_W; ch++) begin
      rep.cw_map[ch] = cw_flag[ch];
      rep.ccw_map[ch] = ccw_flag[ch];
    end
    return rep;
  endfunction

  task automatic note_mismatch(input string what, input step_report_t want,
                               input step_report_t got);
    miss_count++;
    if (miss_count <= 10)
      $display("[%0t] MISMATCH %s: exp step=%0b cw=%02h ccw=%02h, got step=%0b cw=%02h ccw=%02h",
               $realtime, what, want.step_seen, want.cw_map, want.ccw_map,
               got.step_seen, got.cw_map, got.ccw_map);
  endtask

  always @(posedge clk) begin
    step_report_t got;
    step_report_t want;
    if (rst) begin
      ceiling = CEILING_RESET;
      threshold = THRESHOLD_RESET;
      swap = 1'b0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        clk_count[ch] = '0;
        dt_count[ch] = '0;
        last_clk[ch] = 1'b0;
        cw_flag[ch] = 1'b0;
        ccw_flag[ch] = 1'b0;
      end
      expected_reports.delete();
      awaiting <= 0;
    end else begin
      // results first: a result never belongs to the command taken at the same edge
      if (m_tvalid && m_tready) begin
        got.step_seen = m_tdata[0];
        got.cw_map = m_tdata[8:1];
        got.ccw_map = m_tdata[16:9];
        if (expected_reports.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) note_mismatch("result", want, got);
        end
      end
      if (s_tvalid && s_tready)
        expected_reports.push_back(decode_command(kind_t'(s_tuser), s_tdata[7:0],
                                                  s_tdata[15:8], s_tdata[18:16]));
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_CEILING:   ceiling = pwdata[CNT_W-1:0];
          REG_THRESHOLD: threshold = pwdata[CNT_W-1:0];
          REG_SWAP:      swap = pwdata[0];
          default: ;
        endcase
      end
      awaiting <= expected_reports.size();
    end
  end

endmodule

>>> sim/tb_top.sv
// Testbench top for the rotary encoder decoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
  import rotenc_pkg::*;

  // index with no register behind it; writes there must be dropped
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [1:0]             s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_W-1:0]      paddr;
  logic [DATA_W-1:0]      pwdata;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  int  mismatches;
  int  awaiting;

  // flow-control knobs, written only by the stimulus process
  logic no_idle;     // both sides go flat out while set
  logic hold_armed;  // asks the result sink for one long hold-off

  rotary_encoder_filter_decoder uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rotenc_checker scoreboard (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .mismatches(mismatches),
    .awaiting  (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("rotary_encoder_filter_decoder test failed");
    $finish;
  end

  // Result sink. m_tready is randomized each cycle; once hold_armed goes
  // high it is held low for a long stretch so the two-deep pipe fills and
  // s_tready drops while the source keeps offering.
  initial begin : result_sink
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_idle || ($urandom_range(99) >= 31);
      end
    end
  end

  // One command transfer. Optional random gap first, then hold tvalid until
  // the transfer completes. tvalid is left high so back-to-back commands
  // never drop it; drain() lowers it at the end of a phase.
  task automatic encoder_cmd(input kind_t kind, input logic [PIN_W-1:0] clk_lv,
                             input logic [PIN_W-1:0] dt_lv, input logic [CHAN_W-1:0] chan);
    if (!no_idle) begin
      while ($urandom_range(99) < 31) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{IN_PAD_W{1'b0}}, chan, dt_lv, clk_lv};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering and wait until every expected result has come back.
  // The first edge lets the scoreboard's count catch the last transfer.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write: setup phase, access phase until pready, then back to idle.
  // Upper data bits carry junk; only the register's own bits count.
  task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
    logic [DATA_W-1:0] junk;
    junk = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[DATA_W-1:8], value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic. Pins mostly drift (each bit flips now and then) so the
  // debounce counters actually cross the threshold and edges get detected;
  // a small share is raw noise. slow makes pins flip rarely, for high
  // thresholds.
  task automatic run_random(input int count, input bit slow);
    logic [PIN_W-1:0] clk_lv;
    logic [PIN_W-1:0] dt_lv;
    logic [PIN_W-1:0] flip_c;
    logic [PIN_W-1:0] flip_d;
    int pick;
    clk_lv = PIN_W'($urandom);
    dt_lv = PIN_W'($urandom);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        flip_c = PIN_W'($urandom & $urandom & $urandom);
        flip_d = PIN_W'($urandom & $urandom & $urandom);
        if (slow) begin
          flip_c = flip_c & PIN_W'($urandom & $urandom);
          flip_d = flip_d & PIN_W'($urandom & $urandom);
        end
        clk_lv = clk_lv ^ flip_c;
        dt_lv = dt_lv ^ flip_d;
        encoder_cmd(KIND_SAMPLE, clk_lv, dt_lv, CHAN_W'($urandom));
      end else if (pick < 52) begin
        encoder_cmd(KIND_SAMPLE, PIN_W'($urandom), PIN_W'($urandom), CHAN_W'($urandom));
      end else if (pick < 70) begin
        encoder_cmd(KIND_DETECT, PIN_W'($urandom), PIN_W'($urandom), CHAN_W'($urandom));
      end else if (pick < 85) begin
        encoder_cmd(KIND_READ_CW, PIN_W'($urandom), PIN_W'($urandom), CHAN_W'($urandom));
      end else begin
        encoder_cmd(KIND_READ_CCW, PIN_W'($urandom), PIN_W'($urandom), CHAN_W'($urandom));
      end
    end
  endtask

  // Reprogram all three registers (block idle), run traffic, drain.
  task automatic run_phase(input logic [7:0] ceiling, input logic [7:0] threshold,
                           input bit swap, input int count, input bit slow);
    write_register(REG_CEILING, ceiling);
    write_register(REG_THRESHOLD, threshold);
    write_register(REG_SWAP, {7'($urandom), swap});
    run_random(count, slow);
    drain();
  endtask

  initial begin : stimulus
    logic [7:0] rand_ceiling;
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tuser    <= KIND_SAMPLE;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    no_idle    <= 1'b0;
    hold_armed <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed, reset registers (ceiling 10, threshold 3, no swap) ---
    // all pins high: clock rises with data high -> counter-clockwise everywhere
    repeat (4) encoder_cmd(KIND_SAMPLE, 8'hFF, 8'hFF, 3'd0);
    encoder_cmd(KIND_DETECT, 8'h00, 8'h00, 3'd0);
    encoder_cmd(KIND_READ_CCW, 8'h00, 8'h00, 3'd0);  // set -> seen, cleared
    encoder_cmd(KIND_READ_CCW, 8'h00, 8'h00, 3'd0);  // already cleared
    encoder_cmd(KIND_READ_CW, 8'hFF, 8'hFF, 3'd7);   // never set
    // everything low, falling edge gives no flag
    repeat (4) encoder_cmd(KIND_SAMPLE, 8'h00, 8'h00, 3'd5);
    encoder_cmd(KIND_DETECT, 8'h00, 8'h00, 3'd0);
    // even clocks rise with data low -> clockwise on even channels
    repeat (4) encoder_cmd(KIND_SAMPLE, 8'h55, 8'hAA, 3'd2);
    encoder_cmd(KIND_DETECT, 8'h00, 8'h00, 3'd0);
    // odd clocks rise with data high; odd ccw flags still set, so dropped
    repeat (4) encoder_cmd(KIND_SAMPLE, 8'hAA, 8'hFF, 3'd4);
    encoder_cmd(KIND_DETECT, 8'h00, 8'h00, 3'd0);
    encoder_cmd(KIND_READ_CW, 8'h00, 8'h00, 3'd2);
    encoder_cmd(KIND_READ_CCW, 8'h00, 8'h00, 3'd7);
    encoder_cmd(KIND_READ_CCW, 8'h00, 8'h00, 3'd6);
    drain();

    // write to the unused slot must not disturb anything
    write_register(REG_SPARE, 8'h00);

    // --- random phases ---
    // top ceiling first so counters climb high; the next phase lowers the
    // ceiling under them (counter above ceiling)
    run_phase(8'd255, 8'd20, 1'b1, 100, 1'b1);
    run_phase(8'd1, 8'd0, 1'b0, 100, 1'b0);
    run_phase(8'd0, 8'd0, 1'b1, 60, 1'b0);       // ceiling zero: no edges
    run_phase(8'd5, 8'd5, 1'b0, 50, 1'b0);       // threshold equal to ceiling
    run_phase(8'd200, 8'd255, 1'b1, 40, 1'b0);   // threshold at the top
    rand_ceiling = 8'($urandom_range(12, 1));
    no_idle <= 1'b1;                              // one stretch with no gaps
    run_phase(rand_ceiling, 8'($urandom_range(rand_ceiling - 1, 0)), 1'($urandom), 90, 1'b0);
    no_idle <= 1'b0;
    rand_ceiling = 8'($urandom_range(12, 1));
    hold_armed <= 1'b1;                           // long sink stall in this phase
    run_phase(rand_ceiling, 8'($urandom_range(rand_ceiling - 1, 0)), 1'($urandom), 90, 1'b0);
    rand_ceiling = 8'($urandom_range(12, 1));
    run_phase(rand_ceiling, 8'($urandom_range(rand_ceiling - 1, 0)), 1'($urandom), 90, 1'b0);
    run_phase(CEILING_RESET, THRESHOLD_RESET, 1'b0, 80, 1'b0);

    if (mismatches == 0 && awaiting == 0)
      $display("rotary_encoder_filter_decoder test passed");
    else
      $display("rotary_encoder_filter_decoder test failed");
    $finish;
  end

endmodule
